FILE: sv/mru_id_list_distinct_counter_assert.svh
// assertion macros used by the asserting design file
`ifndef MRU_ID_LIST_DISTINCT_COUNTER_ASSERT_SVH
`define MRU_ID_LIST_DISTINCT_COUNTER_ASSERT_SVH

// same-cycle implication, off during reset
`define MITC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define MITC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/mitc_pkg.sv
`timescale 1ns / 1ps
package mitc_pkg;

  localparam int ID_W    = 32;
  localparam int COUNT_W = 16;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [MODE_W-1:0] MODE_WON     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOST    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRADE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_INVALID = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNTING_ENABLED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATS_CARD_PRESENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT        = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT_RESET = 16'd999;

  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic inc_won;
    logic inc_lost;
    logic inc_trade;
  } cnt_inc_t;

  typedef struct packed {
    count_t won;
    count_t lost;
    count_t trade;
  } cnt_totals_t;

endpackage

FILE: sv/mitc_in_if.sv
`timescale 1ns / 1ps
interface mitc_in_if import mitc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   partner_id;

  modport source (output valid, output mode, output partner_id, input ready);
  modport sink   (input valid, input mode, input partner_id, output ready);
endinterface

FILE: sv/mitc_out_if.sv
`timescale 1ns / 1ps
interface mitc_out_if import mitc_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   bad_mode;
  logic   new_partner;
  logic   counted;
  count_t won_total;
  count_t lost_total;
  count_t trade_total;

  modport source (output valid, output bad_mode, output new_partner, output counted,
                  output won_total, output lost_total, output trade_total, input ready);
  modport sink   (input valid, input bad_mode, input new_partner, input counted,
                  input won_total, input lost_total, input trade_total, output ready);
endinterface

FILE: sv/mitc_cfg_if.sv
`timescale 1ns / 1ps
interface mitc_cfg_if import mitc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: sv/mru_id_list_distinct_counter.sv
`timescale 1ns / 1ps
// Recent-partner event counter. Each input word carries an event kind (battle won,
// battle lost, trade, invalid) and a 32-bit partner id; battles share one
// move-to-front list of LIST_DEPTH ids and trades use another. With counting on, a
// missing id goes to the front of its list and, with a stats card, bumps that event's
// counter, saturating at count_limit; a hit only moves the id to the front. One result
// per input word passes the input register, list compare, shift, counter add and
// result register; a new word is taken every cycle unless stalled. Configuration is
// written via the cfg channel (index 0 counting_enabled, 1 stats_card_present, 2
// count_limit) while no word is in flight; the user must ensure it, not the block.
`include "mru_id_list_distinct_counter_assert.svh"
module mru_id_list_distinct_counter import mitc_pkg::*; #(
  parameter int LIST_DEPTH = 8
) (
  input  logic clk,
  input  logic rst,
  mitc_cfg_if.sink   cfg,
  mitc_in_if.sink    item_in,
  mitc_out_if.source result_out
);

  logic   counting_enabled;
  logic   stats_card_present;
  count_t count_limit;

  logic              in_valid;
  logic [MODE_W-1:0] in_mode;
  logic [ID_W-1:0]   in_id;

  logic        advance;
  logic        is_bad;
  logic        is_trade;
  logic        active;
  logic        battle_miss;
  logic        trade_miss;
  logic        fresh;
  logic        do_count;
  cnt_inc_t    inc;
  cnt_totals_t totals_next;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      counting_enabled   <= 1'b0;
      stats_card_present <= 1'b0;
      count_limit        <= COUNT_LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_COUNTING_ENABLED:   counting_enabled   <= cfg.wdata[0];
        CFG_STATS_CARD_PRESENT: stats_card_present <= cfg.wdata[0];
        CFG_COUNT_LIMIT:        count_limit        <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // input register, drained whenever the result register can take its word
  assign advance       = in_valid && (!result_out.valid || result_out.ready);
  assign item_in.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_in.valid && item_in.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      in_mode <= item_in.mode;
      in_id   <= item_in.partner_id;
    end
  end

  assign is_bad   = (in_mode == MODE_INVALID);
  assign is_trade = (in_mode == MODE_TRADE);
  assign active   = !is_bad && counting_enabled;

  mitc_mtf_list #(.DEPTH(LIST_DEPTH)) u_battle_list (
    .clk  (clk),
    .rst  (rst),
    .upd  (advance && active && !is_trade),
    .id   (in_id),
    .miss (battle_miss)
  );

  mitc_mtf_list #(.DEPTH(LIST_DEPTH)) u_trade_list (
    .clk  (clk),
    .rst  (rst),
    .upd  (advance && active && is_trade),
    .id   (in_id),
    .miss (trade_miss)
  );

  assign fresh    = active && (is_trade ? trade_miss : battle_miss);
  assign do_count = fresh && stats_card_present;

  always_comb begin
    inc.inc_won   = advance && do_count && (in_mode == MODE_WON);
    inc.inc_lost  = advance && do_count && (in_mode == MODE_LOST);
    inc.inc_trade = advance && do_count && is_trade;
  end

  mitc_counters u_counters (
    .clk         (clk),
    .rst         (rst),
    .inc         (inc),
    .limit       (count_limit),
    .totals_next (totals_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (advance) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_out.bad_mode    <= is_bad;
      result_out.new_partner <= fresh;
      result_out.counted     <= do_count;
      result_out.won_total   <= totals_next.won;
      result_out.lost_total  <= totals_next.lost;
      result_out.trade_total <= totals_next.trade;
    end
  end

  `MITC_ASSERT_NOW(a_bad_is_quiet, clk, rst, result_out.valid && result_out.bad_mode, !result_out.new_partner && !result_out.counted, "invalid event reported as new or counted")
  `MITC_ASSERT_NOW(a_counted_needs_new, clk, rst, result_out.valid && result_out.counted, result_out.new_partner, "count raised on a list hit")
  `MITC_ASSERT_NEXT(a_advance_fills_out, clk, rst, advance, result_out.valid, "processed word did not reach the result register")
  `MITC_ASSERT_NOW(a_one_counter_moves, clk, rst, 1'b1, $onehot0({inc.inc_won, inc.inc_lost, inc.inc_trade}), "more than one counter updated for one word")

endmodule

FILE: sv/mitc_mtf_list.sv
`timescale 1ns / 1ps
module mitc_mtf_list import mitc_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            upd,
  input  logic [ID_W-1:0] id,
  output logic            miss
);

  logic [ID_W-1:0] ids [DEPTH];
  logic [DEPTH-1:0] hit;
  logic [DEPTH-1:0] shift;

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      hit[k] = (ids[k] == id);
    end
  end

  assign miss = ~|hit;

  // slot k takes slot k-1 unless the id sits in front of it
  assign shift[0] = 1'b1;
  for (genvar k = 1; k < DEPTH; k++) begin : g_shift
    assign shift[k] = ~|hit[k-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        ids[k] <= '0;
      end
    end else if (upd) begin
      ids[0] <= id;
      for (int k = 1; k < DEPTH; k++) begin
        if (shift[k]) begin
          ids[k] <= ids[k-1];
        end
      end
    end
  end

endmodule

FILE: sv/mitc_counters.sv
`timescale 1ns / 1ps
module mitc_counters import mitc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cnt_inc_t    inc,
  input  count_t      limit,
  output cnt_totals_t totals_next
);

  cnt_totals_t totals;

  function automatic count_t sat_inc(input count_t v, input count_t lim);
    logic [COUNT_W:0] n;
    n = {1'b0, v} + {{COUNT_W{1'b0}}, 1'b1};
    return (n > {1'b0, lim}) ? lim : n[COUNT_W-1:0];
  endfunction

  always_comb begin
    totals_next = totals;
    if (inc.inc_won) begin
      totals_next.won = sat_inc(totals.won, limit);
    end
    if (inc.inc_lost) begin
      totals_next.lost = sat_inc(totals.lost, limit);
    end
    if (inc.inc_trade) begin
      totals_next.trade = sat_inc(totals.trade, limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      totals <= '0;
    end else begin
      totals <= totals_next;
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
module tb import mitc_pkg::*; ();

  localparam int LIST_DEPTH = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic   bad_mode;
    logic   new_partner;
    logic   counted;
    count_t won;
    count_t lost;
    count_t trade;
  } event_result_t;

  logic clk = 1'b0;
  logic rst;

  mitc_cfg_if cfg_if ();
  mitc_in_if  in_if ();
  mitc_out_if out_if ();

  mru_id_list_distinct_counter #(.LIST_DEPTH(LIST_DEPTH)) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_if),
    .item_in    (in_if),
    .result_out (out_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the block state
  logic [ID_W-1:0] battle_ids [LIST_DEPTH];
  logic [ID_W-1:0] trade_ids [LIST_DEPTH];
  count_t          won_cnt;
  count_t          lost_cnt;
  count_t          trade_cnt;
  logic            cfg_enabled;
  logic            cfg_stats;
  count_t          cfg_limit;

  event_result_t pending_results [$];
  int errors = 0;

  int gaps_on = 1;
  int tx_burst_left = 0;
  int hold_left = 0;
  int rx_style = 0;
  int rx_left = 0;
  int rx_tick = 0;

  function automatic count_t sat_next(count_t v);
    logic [COUNT_W:0] n;
    n = {1'b0, v} + {{COUNT_W{1'b0}}, 1'b1};
    if (n > {1'b0, cfg_limit})
      n = {1'b0, cfg_limit};
    return n[COUNT_W-1:0];
  endfunction

  function automatic event_result_t predict_event(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id);
    event_result_t   r;
    logic [ID_W-1:0] lst [LIST_DEPTH];
    int              pos;
    int              top;
    r = '0;
    if (mode == MODE_INVALID) begin
      r.bad_mode = 1'b1;
    end else if (cfg_enabled) begin
      if (mode == MODE_TRADE)
        lst = trade_ids;
      else
        lst = battle_ids;
      pos = LIST_DEPTH;
      for (int k = 0; k < LIST_DEPTH; k++)
        if (pos == LIST_DEPTH && lst[k] == id)
          pos = k;
      // a miss shifts the whole list, dropping the oldest id
      top = (pos == LIST_DEPTH) ? LIST_DEPTH - 1 : pos;
      for (int k = top; k > 0; k--)
        lst[k] = lst[k-1];
      lst[0] = id;
      if (mode == MODE_TRADE)
        trade_ids = lst;
      else
        battle_ids = lst;
      if (pos == LIST_DEPTH) begin
        r.new_partner = 1'b1;
        if (cfg_stats) begin
          r.counted = 1'b1;
          case (mode)
            MODE_WON:  won_cnt = sat_next(won_cnt);
            MODE_LOST: lost_cnt = sat_next(lost_cnt);
            default:   trade_cnt = sat_next(trade_cnt);
          endcase
        end
      end
    end
    r.won   = won_cnt;
    r.lost  = lost_cnt;
    r.trade = trade_cnt;
    return r;
  endfunction

  task automatic pause_sender(int cycles);
    @(negedge clk);
    in_if.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_event(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id);
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.mode       <= mode;
    in_if.partner_id <= id;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(predict_event(mode, id));
    if (gaps_on != 0) begin
      if (tx_burst_left == 0) begin
        pause_sender($urandom_range(1, 8));
        tx_burst_left = $urandom_range(1, 16);
      end else begin
        tx_burst_left--;
      end
    end
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_COUNTING_ENABLED:   cfg_enabled = data[0];
      CFG_STATS_CARD_PRESENT: cfg_stats = data[0];
      CFG_COUNT_LIMIT:        cfg_limit = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // every word gives one result, so an empty queue plus the pipe depth means idle
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic en, logic stats, count_t limit);
    wait_idle();
    write_register(CFG_COUNTING_ENABLED, {15'($urandom), en});
    write_register(CFG_STATS_CARD_PRESENT, {15'($urandom), stats});
    write_register(CFG_COUNT_LIMIT, limit);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    event_result_t want_r;
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no pending event");
        errors++;
      end else begin
        want_r = pending_results.pop_front();
        check_field("bad_mode", 32'(want_r.bad_mode), 32'(out_if.bad_mode));
        check_field("new_partner", 32'(want_r.new_partner), 32'(out_if.new_partner));
        check_field("counted", 32'(want_r.counted), 32'(out_if.counted));
        check_field("won_total", 32'(want_r.won), 32'(out_if.won_total));
        check_field("lost_total", 32'(want_r.lost), 32'(out_if.lost_total));
        check_field("trade_total", 32'(want_r.trade), 32'(out_if.trade_total));
      end
    end
  end

  // receiver stall pattern, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      if (rx_left == 0) begin
        rx_style = $urandom_range(0, 3);
        rx_left  = $urandom_range(16, 160);
      end
      rx_left--;
      rx_tick++;
      case (rx_style)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= ((rx_tick % 7) < 3);
        default: out_if.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  task automatic test_counting_disabled();
    send_event(MODE_WON, 32'h0000_0000);
    send_event(MODE_LOST, 32'hFFFF_FFFF);
    send_event(MODE_TRADE, 32'h0000_0000);
    send_event(MODE_INVALID, 32'hFFFF_FFFF);
  endtask

  task automatic test_list_without_stats();
    set_config(1'b1, 1'b0, COUNT_LIMIT_RESET);
    // zeros left by reset make id 0 a hit
    send_event(MODE_WON, 32'h0000_0000);
    send_event(MODE_TRADE, 32'hDEAD_BEEF);
    send_event(MODE_TRADE, 32'hDEAD_BEEF);
    send_event(MODE_LOST, 32'hFFFF_FFFF);
  endtask

  task automatic test_saturation();
    set_config(1'b1, 1'b1, 16'd2);
    send_event(MODE_WON, 32'd1);
    send_event(MODE_WON, 32'd2);
    send_event(MODE_WON, 32'd3);
    send_event(MODE_WON, 32'd2);
    // the battle list is shared between won and lost
    send_event(MODE_LOST, 32'd1);
    send_event(MODE_TRADE, 32'd1);
    send_event(MODE_INVALID, 32'd5);
    for (int k = 0; k < LIST_DEPTH; k++)
      send_event(MODE_LOST, 32'h100 + k);
    send_event(MODE_WON, 32'd1);
  endtask

  task automatic test_limit_changes();
    // counter above the new limit drops to it on the next miss
    set_config(1'b1, 1'b1, 16'd0);
    send_event(MODE_WON, 32'h1234_5678);
    set_config(1'b1, 1'b1, 16'hFFFF);
    write_register(CFG_UNUSED_IDX, 16'($urandom));
    send_event(MODE_TRADE, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_traffic();
    logic [ID_W-1:0]   id_pool [16];
    int                pool_size;
    int                pick;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
    count_t            limit;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: limit = 16'd0;
        1: limit = 16'hFFFF;
        2: limit = 16'($urandom_range(1, 40));
        default: limit = 16'($urandom);
      endcase
      set_config($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 80, limit);
      gaps_on   = ($urandom_range(0, 3) != 0);
      pool_size = $urandom_range(4, 16);
      for (int k = 0; k < 16; k++)
        id_pool[k] = $urandom;
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int n = 0; n < 250; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 65)
          id = id_pool[$urandom_range(0, pool_size - 1)];
        else if (pick < 72)
          id = '0;
        else if (pick < 78)
          id = '1;
        else
          id = $urandom;
        if ($urandom_range(0, 99) < 8)
          mode = MODE_INVALID;
        else
          mode = MODE_TRADE - 2'($urandom_range(0, 2));
        send_event(mode, id);
      end
    end
    gaps_on = 1;
  endtask

  task automatic test_backpressure();
    set_config(1'b1, 1'b1, 16'd500);
    gaps_on = 0;
    @(posedge clk);
    hold_left = 300;
    for (int n = 0; n < 150; n++)
      send_event(MODE_TRADE - 2'($urandom_range(0, 3) % 3), 32'($urandom_range(0, 11)));
    // sender waits for the pipe to drain completely
    wait_idle();
    gaps_on = 1;
    for (int n = 0; n < 50; n++)
      send_event(2'($urandom_range(0, 3)), $urandom);
  endtask

  initial begin
    rst              = 1'b1;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.wdata     = '0;
    in_if.valid      = 1'b0;
    in_if.mode       = '0;
    in_if.partner_id = '0;
    out_if.ready     = 1'b0;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      battle_ids[k] = '0;
      trade_ids[k]  = '0;
    end
    won_cnt     = '0;
    lost_cnt    = '0;
    trade_cnt   = '0;
    cfg_enabled = 1'b0;
    cfg_stats   = 1'b0;
    cfg_limit   = COUNT_LIMIT_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_counting_disabled();
    test_list_without_stats();
    test_saturation();
    test_limit_changes();
    test_random_traffic();
    test_backpressure();

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
